/* rtl/core/lfia_pkg.sv */
// Shared constants and types of the lowest-free identifier allocator.
`default_nettype none
package lfia_pkg;

  localparam int DEF_POOL_SIZE    = 256;
  localparam int DEF_FIRST_USABLE = 2;

  // bitmap word geometry
  localparam int WORD_W = 32;
  localparam int BIT_W  = $clog2(WORD_W);

  typedef enum logic [1:0] {
    ST_OK          = 2'd0,
    ST_EMPTY       = 2'd1,
    ST_BAD_RELEASE = 2'd2
  } status_t;

  // result of the find-first-zero unit
  typedef struct packed {
    logic             found;
    logic [BIT_W-1:0] idx;
  } ffz_t;

endpackage
`default_nettype wire

/* rtl/core/lfia_ffz.sv */
// Find-first-zero unit: lowest clear bit of one bitmap word.
`default_nettype none
module lfia_ffz (
  input  logic [lfia_pkg::WORD_W-1:0] word,
  output lfia_pkg::ffz_t              res
);

  localparam int NBYTES = lfia_pkg::WORD_W / 8;
  localparam int SEL_W  = lfia_pkg::BIT_W - 3;

  logic [NBYTES-1:0] byte_has;
  logic [2:0]        byte_idx [NBYTES];

  // lowest zero inside each byte
  always_comb begin
    for (int b = 0; b < NBYTES; b++) begin
      byte_has[b] = ~&word[8*b +: 8];
      byte_idx[b] = 3'd0;
      for (int j = 7; j >= 0; j--) begin
        if (!word[8*b + j]) begin
          byte_idx[b] = 3'(j);
        end
      end
    end
  end

  // pick the lowest byte that holds a zero
  always_comb begin
    res.found = |byte_has;
    res.idx   = '0;
    for (int b = NBYTES - 1; b >= 0; b--) begin
      if (byte_has[b]) begin
        res.idx = {SEL_W'(b), byte_idx[b]};
      end
    end
  end

endmodule
`default_nettype wire

/* rtl/core/lowest_free_id_allocator_top.sv */
// Top level of the lowest-free identifier allocator with its bitmap memory and sequencer.
`default_nettype none
// Hands out identifiers from a pool of POOL_SIZE entries, always the lowest free
// one, and takes them back on release. Identifiers below FIRST_USABLE are reserved.
// Each request on the slave stream carries the operation in s_tuser (0 allocate,
// 1 release) and the identifier to free in s_tdata; each request yields exactly one
// result on the master stream with a status in s_tuser's counterpart m_tuser, the
// granted identifier and the free count after the request. Occupancy lives in a
// memory of 32-bit words; one find-first-zero unit is reused for every word that
// the upward scan visits after an allocate. A release or an allocate reads the
// bitmap word of its identifier, and the scan for the next free identifier reads
// every further word it has to (one memory read and one pass of the find-first-zero
// unit per word); no new request is taken until the result is in the output register.
// A request refused at once (empty pool, reserved or out-of-pool identifier) skips
// the word read; a release of an already free identifier is only seen after the word read.
// After reset the block clears the bitmap one word a cycle and holds s_tready
// low meanwhile. A finished result waits in the output
// register while the next request is taken; a later result that finds the output
// register still full holds the sequencer, and s_tready low, until it is taken.
// Results with granted_id and free_count keep only their low 8 and 9 bits.
module lowest_free_id_allocator_top #(
  parameter int POOL_SIZE    = lfia_pkg::DEF_POOL_SIZE,
  parameter int FIRST_USABLE = lfia_pkg::DEF_FIRST_USABLE
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // [7:0] released_id
  input  logic [0:0]  s_tuser,   // [0] func
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [23:0] m_tdata,   // [7:0] granted_id, [16:8] free_count, [23:17] zero
  output logic [1:0]  m_tuser    // [1:0] status
);

  localparam int WORD_W = lfia_pkg::WORD_W;
  localparam int BIT_W  = lfia_pkg::BIT_W;
  localparam int WORDS  = (POOL_SIZE + WORD_W - 1) / WORD_W;
  localparam int WA_W   = (WORDS > 1) ? $clog2(WORDS) : 1;
  localparam int PTR_W  = WA_W + BIT_W;
  localparam int CNT_W  = $clog2(POOL_SIZE + 1);
  localparam int RID_W  = 8;
  localparam int XW     = PTR_W + RID_W;

  localparam logic [PTR_W:0]   POOL_P  = (PTR_W + 1)'(POOL_SIZE);
  localparam logic [XW-1:0]    POOL_X  = XW'(POOL_SIZE);
  localparam logic [XW-1:0]    FIRST_X = XW'(FIRST_USABLE);
  localparam logic [PTR_W-1:0] FIRST_P = PTR_W'(FIRST_USABLE);
  localparam logic [CNT_W-1:0] FREE_RST = CNT_W'(POOL_SIZE - FIRST_USABLE);
  localparam logic [WA_W-1:0]  LAST_WA  = WA_W'(WORDS - 1);

  typedef enum logic [6:0] {
    S_CLEAR   = 7'b0000001,
    S_IDLE    = 7'b0000010,
    S_FETCH   = 7'b0000100,
    S_MODIFY  = 7'b0001000,
    S_SCAN_RD = 7'b0010000,
    S_SCAN    = 7'b0100000,
    S_DONE    = 7'b1000000
  } state_t;

  state_t state, state_next;

  // bitmap memory, one bit per identifier, set = occupied
  logic [WORD_W-1:0] mem [WORDS];
  logic [WORD_W-1:0] rdata;
  logic              mem_we;
  logic [WA_W-1:0]   mem_waddr;
  logic [WORD_W-1:0] mem_wdata;

  logic [WA_W-1:0]   clr_addr, clr_addr_next;
  logic [WA_W-1:0]   word_addr, word_addr_next;
  logic [PTR_W-1:0]  lowest_free, lowest_free_next;
  logic [CNT_W-1:0]  free_total, free_total_next;
  logic [PTR_W-1:0]  target, target_next;
  logic              is_release, is_release_next;
  lfia_pkg::status_t res_status, res_status_next;
  logic [PTR_W-1:0]  res_grant, res_grant_next;

  logic              out_valid;
  lfia_pkg::status_t out_status;
  logic [7:0]        out_grant;
  logic [8:0]        out_count;

  logic [XW-1:0]     rid_x;
  logic              rid_ok;
  logic [WORD_W-1:0] clr_word;
  logic [WORD_W-1:0] bit_mask;
  logic [WORD_W-1:0] ffz_word;
  lfia_pkg::ffz_t    ffz;
  logic              out_free;
  logic [XW-1:0]     grant_x;
  logic [PTR_W+8:0]  count_x;

  lfia_ffz u_ffz (
    .word (ffz_word),
    .res  (ffz)
  );

  // release range check in a width that holds both the request and the pool size
  assign rid_x  = {{PTR_W{1'b0}}, s_tdata};
  assign rid_ok = (rid_x < POOL_X) && (rid_x >= FIRST_X);

  // reset pattern of the word being cleared: reserved ids and ids past the pool occupied
  always_comb begin
    logic [PTR_W-1:0] idj;
    for (int j = 0; j < WORD_W; j++) begin
      idj = {clr_addr, BIT_W'(j)};
      clr_word[j] = (idj < FIRST_P) || ({1'b0, idj} >= POOL_P);
    end
  end

  assign bit_mask = WORD_W'(1) << target[BIT_W-1:0];

  // the unit sees the word with the grant already marked, or a freshly read word
  assign ffz_word = (state == S_MODIFY) ? (rdata | bit_mask) : rdata;

  assign out_free = !out_valid || m_tready;
  assign s_tready = (state == S_IDLE);

  always_comb begin
    state_next       = state;
    clr_addr_next    = clr_addr;
    word_addr_next   = word_addr;
    lowest_free_next = lowest_free;
    free_total_next  = free_total;
    target_next      = target;
    is_release_next  = is_release;
    res_status_next  = res_status;
    res_grant_next   = res_grant;
    mem_we           = 1'b0;
    mem_waddr        = word_addr;
    mem_wdata        = rdata;

    unique case (state)
      S_CLEAR: begin
        // sweep the bitmap to its reset pattern
        mem_we        = 1'b1;
        mem_waddr     = clr_addr;
        mem_wdata     = clr_word;
        clr_addr_next = clr_addr + 1'b1;
        if (clr_addr == LAST_WA) begin
          state_next = S_IDLE;
        end
      end
      S_IDLE: begin
        if (s_tvalid) begin
          is_release_next = s_tuser[0];
          res_grant_next  = '0;
          if (s_tuser[0]) begin
            target_next    = rid_x[PTR_W-1:0];
            word_addr_next = rid_x[PTR_W-1:BIT_W];
            if (rid_ok) begin
              state_next = S_FETCH;
            end else begin
              res_status_next = lfia_pkg::ST_BAD_RELEASE;
              state_next      = S_DONE;
            end
          end else begin
            target_next    = lowest_free;
            word_addr_next = lowest_free[PTR_W-1:BIT_W];
            if (free_total == '0) begin
              res_status_next = lfia_pkg::ST_EMPTY;
              state_next      = S_DONE;
            end else begin
              state_next = S_FETCH;
            end
          end
        end
      end
      S_FETCH: begin
        state_next = S_MODIFY;
      end
      S_MODIFY: begin
        state_next      = S_DONE;
        res_status_next = lfia_pkg::ST_OK;
        if (is_release) begin
          if ((rdata & bit_mask) == '0) begin
            res_status_next = lfia_pkg::ST_BAD_RELEASE;
          end else begin
            mem_we    = 1'b1;
            mem_wdata = rdata & ~bit_mask;
            if ((free_total == '0) || (target < lowest_free)) begin
              lowest_free_next = target;
            end
            free_total_next = free_total + 1'b1;
          end
        end else begin
          // mark the grant; ids below it are occupied, so the scan only looks upward
          mem_we          = 1'b1;
          mem_wdata       = rdata | bit_mask;
          res_grant_next  = target;
          free_total_next = free_total - 1'b1;
          if (free_total != CNT_W'(1)) begin
            if (ffz.found) begin
              lowest_free_next = {word_addr, ffz.idx};
            end else begin
              word_addr_next = word_addr + 1'b1;
              state_next     = S_SCAN_RD;
            end
          end
        end
      end
      S_SCAN_RD: begin
        state_next = S_SCAN;
      end
      S_SCAN: begin
        if (ffz.found) begin
          lowest_free_next = {word_addr, ffz.idx};
          state_next       = S_DONE;
        end else begin
          word_addr_next = word_addr + 1'b1;
          state_next     = S_SCAN_RD;
        end
      end
      S_DONE: begin
        // hold until the output register is free
        if (out_free) begin
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_CLEAR;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    rdata <= mem[word_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_CLEAR;
      clr_addr    <= '0;
      lowest_free <= FIRST_P;
      free_total  <= FREE_RST;
    end else begin
      state       <= state_next;
      clr_addr    <= clr_addr_next;
      lowest_free <= lowest_free_next;
      free_total  <= free_total_next;
    end
  end

  always_ff @(posedge clk) begin
    word_addr  <= word_addr_next;
    target     <= target_next;
    is_release <= is_release_next;
    res_status <= res_status_next;
    res_grant  <= res_grant_next;
  end

  // keep only the low bits of wide pool values
  assign grant_x = {{RID_W{1'b0}}, res_grant};
  assign count_x = {{(PTR_W + 9 - CNT_W){1'b0}}, free_total};

  // output register: load a finished result, drop valid once taken
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if ((state == S_DONE) && out_free) begin
      out_valid <= 1'b1;
    end else if (m_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if ((state == S_DONE) && out_free) begin
      out_status <= res_status;
      out_grant  <= grant_x[7:0];
      out_count  <= count_x[8:0];
    end
  end

  assign m_tvalid = out_valid;
  assign m_tdata  = {7'b0, out_count, out_grant};
  assign m_tuser  = out_status;

endmodule
`default_nettype wire
